/* hw/rtl/afil_pkg.sv */
package afil_pkg;

    // field and register widths
    localparam int COUNT_BITS = 31;
    localparam int N_W        = 31;
    localparam int F_W        = 24;
    localparam int P_W        = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // shared divider widths: dividend covers the reflected sample offset,
    // divisor covers twice the buffer length
    localparam int DVD_W  = 44;
    localparam int DVS_W  = 33;
    localparam int DCNT_W = $clog2(DVD_W);

    // locate arithmetic widths
    localparam int PROD_W = F_W + CFG_W;
    localparam int ST_W   = PROD_W + 2;
    localparam int X_W    = ST_W + 1;

    localparam logic [DVD_W-1:0] CNT_MAX = DVD_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic signed [ST_W-1:0] S32_MAX = ST_W'(64'sh7FFF_FFFF);
    localparam logic signed [ST_W-1:0] S32_MIN = ST_W'(-64'sh8000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH = 2'd0,
        REG_FRAME_SHIFT  = 2'd1,
        REG_SNIP_EDGES   = 2'd2
    } t_reg_idx;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    // divider launch and result
    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    // saturate a frame count to the count range
    function automatic logic [N_W-1:0] sat_count(input logic [DVD_W-1:0] v);
        logic [DVD_W-1:0] c;
        c = (v > CNT_MAX) ? CNT_MAX : v;
        return c[N_W-1:0];
    endfunction

endpackage

/* hw/rtl/afil_div.sv */
module afil_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  afil_pkg::t_div_req i_req,
    output afil_pkg::t_div_rsp o_rsp
);
    import afil_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_d;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;
    logic [DVS_W-1:0]  n_rem;
    logic [DVD_W-1:0]  n_q;

    // one restoring step: shift in the next dividend bit, compare, subtract
    always_comb begin
        trial = {r_rem, r_q[DVD_W-1]};
        ge    = (trial >= {1'b0, r_d});
        diff  = trial - {1'b0, r_d};
        n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        n_q   = {r_q[DVD_W-2:0], ge};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DCNT_W'(1);
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_q   <= i_req.dvd;
            r_rem <= '0;
            r_d   <= i_req.dvs;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

/* hw/rtl/audio_frame_index_locator.sv */
// Speech framing address unit. Raise start while busy is low to hand over an
// item; busy goes high at the accepting edge and drops at the edge that puts the
// result out. Every item gives exactly one result, shown on the o_ result ports
// for the single cycle in which o_valid is high; the receiver cannot stall, so it
// must take the result then. Count gives its result without a division when the
// signal is shorter than a frame in snip-edges mode and after one division
// otherwise; rounded mode without flush needs a second division unless no frame
// fits. Locate runs its calculation steps and one division, and skips the
// division for an empty buffer. Divisions use one shared restoring divider that
// retires one quotient bit per cycle over a 44-bit dividend. Configuration writes
// take effect at once; the user must make them only while the block is idle, as
// the block does not enforce it; a length or shift of zero is taken as one.
module audio_frame_index_locator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [afil_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [afil_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [afil_pkg::N_W-1:0]            i_sample_count,
    input  logic                                i_flush,
    input  logic [afil_pkg::F_W-1:0]            i_frame_index,
    input  logic [afil_pkg::P_W-1:0]            i_position,
    input  logic [afil_pkg::N_W-1:0]            i_buffer_offset,
    output logic                                o_valid,
    output logic [afil_pkg::N_W-1:0]            o_frame_count,
    output logic signed [31:0]                  o_frame_origin,
    output logic [afil_pkg::N_W-1:0]            o_buffer_index,
    output logic                                o_bad_request
);
    import afil_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CALC0 = 8'b0000_0010,
        S_CALC1 = 8'b0000_0100,
        S_CALC2 = 8'b0000_1000,
        S_CALC3 = 8'b0001_0000,
        S_DIV1  = 8'b0010_0000,
        S_DIV2  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0] r_len, r_shift;
    logic             r_snip;

    // captured item
    logic             r_cmd, r_flush;
    logic [N_W-1:0]   r_n, r_off;
    logic [F_W-1:0]   r_f;
    logic [P_W-1:0]   r_pos;

    // working registers
    logic [PROD_W-1:0]       r_prod;
    logic signed [ST_W-1:0]  r_start, n_start;
    logic signed [X_W-1:0]   r_x;
    logic                    r_before, r_bad;
    logic [DVD_W-1:0]        r_k;
    logic [DVS_W-1:0]        r_xm;

    // result registers
    logic                    r_valid, n_valid;
    logic [N_W-1:0]          r_fcount, n_fcount;
    logic [31:0]             r_ssample, n_ssample;
    logic [N_W-1:0]          r_bidx, n_bidx;
    logic                    r_bad_o, n_bad_o;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [CFG_W-1:0]        half_s, ceil_s, half_len, ceil_len;
    logic signed [17:0]      ofs;
    logic signed [ST_W-1:0]  ofs_ext, prod_ext;
    logic signed [X_W-1:0]   start_ext, x_calc, end_calc, lim_calc;
    logic signed [32:0]      room;
    logic [X_W-1:0]          x_abs;
    logic [DVS_W-1:0]        period, xm_calc, fold;
    logic [DVD_W-1:0]        q_inc, q_min;
    logic                    before_calc, bad_calc;

    afil_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // framing arithmetic shared by the sequencer steps
    always_comb begin
        half_s    = {1'b0, r_shift[CFG_W-1:1]};
        ceil_s    = r_shift - half_s;
        half_len  = {1'b0, r_len[CFG_W-1:1]};
        ceil_len  = r_len - half_len;
        ofs       = $signed({2'b00, half_s}) - $signed({2'b00, half_len});
        ofs_ext   = {{(ST_W-18){ofs[17]}}, ofs};
        prod_ext  = $signed({2'b00, r_prod});
        n_start   = prod_ext + (r_snip ? ST_W'(0) : ofs_ext);
        start_ext = {r_start[ST_W-1], r_start};
        x_calc    = start_ext - $signed({{(X_W-N_W){1'b0}}, r_off})
                    + $signed({{(X_W-P_W){1'b0}}, r_pos});
        before_calc = (r_start < $signed({{(ST_W-N_W){1'b0}}, r_off}));
        end_calc  = start_ext + $signed({{(X_W-CFG_W){1'b0}}, r_len});
        lim_calc  = $signed({{(X_W-N_W){1'b0}}, r_off})
                    + $signed({{(X_W-N_W){1'b0}}, r_n});
        bad_calc  = (r_n == '0) || ({{(N_W-P_W){1'b0}}, r_pos} >= {{(N_W-CFG_W){1'b0}}, r_len})
                    || (r_snip ? (r_before || (end_calc > lim_calc))
                               : ((r_off != '0) && r_before));
        x_abs     = r_x[X_W-1] ? X_W'(-r_x) : X_W'(r_x);
        room      = $signed({2'b00, r_n}) + $signed({17'b0, ceil_s})
                    - $signed({17'b0, ceil_len});
        period    = {1'b0, r_n, 1'b0};
        xm_calc   = (r_x[X_W-1] && (div_rsp.rem != '0)) ? (period - div_rsp.rem)
                                                         : div_rsp.rem;
        fold      = period - DVS_W'(1) - r_xm;
        q_inc     = div_rsp.quot + DVD_W'(1);
        q_min     = (r_k < div_rsp.quot) ? r_k : div_rsp.quot;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_fcount  = r_fcount;
        n_ssample = r_ssample;
        n_bidx    = r_bidx;
        n_bad_o   = r_bad_o;
        div_req.go  = 1'b0;
        div_req.dvd = '0;
        div_req.dvs = (r_cmd == CMD_LOCATE) ? period : {{(DVS_W-CFG_W){1'b0}}, r_shift};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CALC0;
                end
            end
            S_CALC0: begin
                n_ssample = '0;
                n_bidx    = '0;
                n_bad_o   = 1'b0;
                if (r_cmd == CMD_LOCATE) begin
                    n_state = S_CALC1;
                end else if (r_snip) begin
                    if (r_n < {{(N_W-CFG_W){1'b0}}, r_len}) begin
                        n_fcount = '0;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        div_req.go  = 1'b1;
                        div_req.dvd = DVD_W'(r_n) - DVD_W'(r_len);
                        n_state     = S_DIV1;
                    end
                end else begin
                    div_req.go  = 1'b1;
                    div_req.dvd = DVD_W'(r_n) + DVD_W'(half_s);
                    n_state     = S_DIV1;
                end
            end
            S_CALC1: begin
                n_state = S_CALC2;
            end
            S_CALC2: begin
                n_state = S_CALC3;
            end
            S_CALC3: begin
                if (r_n == '0) begin
                    n_state = S_FIN;
                end else begin
                    div_req.go  = 1'b1;
                    div_req.dvd = DVD_W'(x_abs);
                    n_state     = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    if (r_cmd == CMD_LOCATE) begin
                        n_state = S_FIN;
                    end else if (r_snip) begin
                        n_fcount = sat_count(q_inc);
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_flush) begin
                        n_fcount = sat_count(div_rsp.quot);
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (room < 0) begin
                        n_fcount = '0;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        div_req.go  = 1'b1;
                        div_req.dvd = DVD_W'(room[31:0]);
                        n_state     = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                if (div_rsp.done) begin
                    n_fcount = sat_count(q_min);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FIN: begin
                n_fcount = '0;
                if (r_n == '0) begin
                    n_bidx = '0;
                end else if (r_xm >= {2'b00, r_n}) begin
                    n_bidx = fold[N_W-1:0];
                end else begin
                    n_bidx = r_xm[N_W-1:0];
                end
                if (r_start > S32_MAX) begin
                    n_ssample = S32_MAX[31:0];
                end else if (r_start < S32_MIN) begin
                    n_ssample = S32_MIN[31:0];
                end else begin
                    n_ssample = r_start[31:0];
                end
                n_bad_o = r_bad;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_len   <= CFG_W'(400);
            r_shift <= CFG_W'(160);
            r_snip  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_FRAME_LENGTH: r_len   <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                    REG_FRAME_SHIFT:  r_shift <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                    REG_SNIP_EDGES:   r_snip  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // item capture, working values and results
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cmd   <= i_cmd;
            r_flush <= i_flush;
            r_n     <= i_sample_count;
            r_f     <= i_frame_index;
            r_pos   <= i_position;
            r_off   <= i_buffer_offset;
        end
        if (r_state == S_CALC0) begin
            r_prod <= PROD_W'(r_f * r_shift);
        end
        if (r_state == S_CALC1) begin
            r_start <= n_start;
        end
        if (r_state == S_CALC2) begin
            r_x      <= x_calc;
            r_before <= before_calc;
        end
        if (r_state == S_CALC3) begin
            r_bad <= bad_calc;
        end
        if ((r_state == S_DIV1) && div_rsp.done) begin
            r_k  <= div_rsp.quot;
            r_xm <= xm_calc;
        end
        r_fcount  <= n_fcount;
        r_ssample <= n_ssample;
        r_bidx    <= n_bidx;
        r_bad_o   <= n_bad_o;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_frame_count  = r_fcount;
    assign o_frame_origin = $signed(r_ssample);
    assign o_buffer_index = r_bidx;
    assign o_bad_request  = r_bad_o;

endmodule
